// ===== rtl/kalman_pos_vel_filter_top_assert.svh =====
// assertion macros for the filter rtl
`ifndef KALMAN_POS_VEL_FILTER_TOP_ASSERT_SVH
`define KALMAN_POS_VEL_FILTER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define KPV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define KPV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kpv_pkg.sv =====
package kpv_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int FIELD_W     = 32;
    localparam int TIME_STEP_W = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_Q00      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Q10      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q01      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Q11      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_R        = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_H0       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_H1       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COV_INIT = 4'd7;

    localparam logic [31:0] Q00_RST      = 32'd655;
    localparam logic [31:0] Q11_RST      = 32'd655;
    localparam logic [31:0] R_RST        = 32'd65536;
    localparam logic [31:0] H0_RST       = 32'd65536;
    localparam logic [31:0] COV_DIAG_RST = 32'd65536;

    // program step opcodes
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_MUL = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB = 3'd2;
    localparam logic [OP_W-1:0] OP_SHR = 3'd3;
    localparam logic [OP_W-1:0] OP_MOV = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV = 3'd5;
    localparam logic [OP_W-1:0] OP_BRZ = 3'd6;
    localparam logic [OP_W-1:0] OP_END = 3'd7;

    // operand codes: top bit set selects the scratch memory
    localparam int OPND_W   = 6;
    localparam int TMP_AW   = 5;
    localparam int TMP_DEPTH = 32;
    localparam logic [OPND_W-1:0] S_Q00 = 6'd0;
    localparam logic [OPND_W-1:0] S_Q10 = 6'd1;
    localparam logic [OPND_W-1:0] S_Q01 = 6'd2;
    localparam logic [OPND_W-1:0] S_Q11 = 6'd3;
    localparam logic [OPND_W-1:0] S_R   = 6'd4;
    localparam logic [OPND_W-1:0] S_H0  = 6'd5;
    localparam logic [OPND_W-1:0] S_H1  = 6'd6;
    localparam logic [OPND_W-1:0] S_DT  = 6'd7;
    localparam logic [OPND_W-1:0] S_ACC = 6'd8;
    localparam logic [OPND_W-1:0] S_OBS = 6'd9;
    localparam logic [OPND_W-1:0] S_POS = 6'd10;
    localparam logic [OPND_W-1:0] S_VEL = 6'd11;
    localparam logic [OPND_W-1:0] S_C0  = 6'd12;
    localparam logic [OPND_W-1:0] S_C1  = 6'd13;
    localparam logic [OPND_W-1:0] S_C2  = 6'd14;
    localparam logic [OPND_W-1:0] S_C3  = 6'd15;
    localparam logic [OPND_W-1:0] S_NONE = 6'd0;

    // state destinations
    localparam logic [OPND_W-1:0] D_POS = 6'd0;
    localparam logic [OPND_W-1:0] D_VEL = 6'd1;
    localparam logic [OPND_W-1:0] D_C0  = 6'd2;
    localparam logic [OPND_W-1:0] D_C1  = 6'd3;
    localparam logic [OPND_W-1:0] D_C2  = 6'd4;
    localparam logic [OPND_W-1:0] D_C3  = 6'd5;

    localparam int PC_W    = 7;
    localparam int NUM_UOP = 75;
    localparam logic [PC_W-1:0] SKIP_PC = 7'd68;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        logic [OPND_W-1:0] d;
    } kpv_uop_t;

    function automatic logic [OPND_W-1:0] tmp(input int n);
        return {1'b1, TMP_AW'(n)};
    endfunction

    function automatic kpv_uop_t mk(input logic [OP_W-1:0] op, input logic [OPND_W-1:0] a,
                                    input logic [OPND_W-1:0] b, input logic [OPND_W-1:0] d);
        kpv_uop_t u;
        u.op = op;
        u.a  = a;
        u.b  = b;
        u.d  = d;
        return u;
    endfunction

    // filter step program
    function automatic kpv_uop_t kpv_rom(input logic [PC_W-1:0] pc);
        case (pc)
            // prediction
            7'd0:  return mk(OP_MUL, S_DT,   S_DT,   tmp(0));
            7'd1:  return mk(OP_SHR, tmp(0), S_NONE, tmp(0));
            7'd2:  return mk(OP_MUL, S_DT,   S_VEL,  tmp(1));
            7'd3:  return mk(OP_ADD, S_POS,  tmp(1), tmp(1));
            7'd4:  return mk(OP_MUL, tmp(0), S_ACC,  tmp(2));
            7'd5:  return mk(OP_ADD, tmp(1), tmp(2), tmp(1));
            7'd6:  return mk(OP_MUL, S_DT,   S_ACC,  tmp(2));
            7'd7:  return mk(OP_ADD, S_VEL,  tmp(2), tmp(2));
            7'd8:  return mk(OP_MUL, S_DT,   S_C1,   tmp(3));
            7'd9:  return mk(OP_ADD, S_C0,   tmp(3), tmp(3));
            7'd10: return mk(OP_MUL, S_DT,   S_C3,   tmp(4));
            7'd11: return mk(OP_ADD, S_C2,   tmp(4), tmp(4));
            7'd12: return mk(OP_MUL, tmp(4), S_DT,   tmp(5));
            7'd13: return mk(OP_ADD, tmp(3), tmp(5), tmp(5));
            7'd14: return mk(OP_ADD, tmp(5), S_Q00,  tmp(5));
            7'd15: return mk(OP_MUL, S_C3,   S_DT,   tmp(6));
            7'd16: return mk(OP_ADD, S_C1,   tmp(6), tmp(6));
            7'd17: return mk(OP_ADD, tmp(6), S_Q10,  tmp(6));
            7'd18: return mk(OP_ADD, tmp(4), S_Q01,  tmp(7));
            7'd19: return mk(OP_ADD, S_C3,   S_Q11,  tmp(8));
            // innovation variance
            7'd20: return mk(OP_MUL, S_H0,   tmp(5), tmp(9));
            7'd21: return mk(OP_MUL, S_H1,   tmp(6), tmp(10));
            7'd22: return mk(OP_ADD, tmp(9), tmp(10), tmp(9));
            7'd23: return mk(OP_MUL, tmp(9), S_H0,   tmp(9));
            7'd24: return mk(OP_MUL, S_H0,   tmp(7), tmp(10));
            7'd25: return mk(OP_MUL, S_H1,   tmp(8), tmp(11));
            7'd26: return mk(OP_ADD, tmp(10), tmp(11), tmp(10));
            7'd27: return mk(OP_MUL, tmp(10), S_H1,  tmp(10));
            7'd28: return mk(OP_ADD, tmp(9), tmp(10), tmp(9));
            7'd29: return mk(OP_ADD, tmp(9), S_R,    tmp(9));
            7'd30: return mk(OP_BRZ, tmp(9), S_NONE, S_NONE);
            // gains
            7'd31: return mk(OP_MUL, tmp(5), S_H0,   tmp(10));
            7'd32: return mk(OP_MUL, tmp(7), S_H1,   tmp(11));
            7'd33: return mk(OP_ADD, tmp(10), tmp(11), tmp(10));
            7'd34: return mk(OP_DIV, tmp(10), tmp(9), tmp(10));
            7'd35: return mk(OP_MUL, tmp(6), S_H0,   tmp(11));
            7'd36: return mk(OP_MUL, tmp(8), S_H1,   tmp(12));
            7'd37: return mk(OP_ADD, tmp(11), tmp(12), tmp(11));
            7'd38: return mk(OP_DIV, tmp(11), tmp(9), tmp(11));
            // state correction
            7'd39: return mk(OP_MUL, S_H0,   tmp(1), tmp(12));
            7'd40: return mk(OP_MUL, S_H1,   tmp(2), tmp(13));
            7'd41: return mk(OP_ADD, tmp(12), tmp(13), tmp(12));
            7'd42: return mk(OP_SUB, S_OBS,  tmp(12), tmp(12));
            7'd43: return mk(OP_MUL, tmp(10), tmp(12), tmp(13));
            7'd44: return mk(OP_ADD, tmp(1), tmp(13), D_POS);
            7'd45: return mk(OP_MUL, tmp(11), tmp(12), tmp(13));
            7'd46: return mk(OP_ADD, tmp(2), tmp(13), D_VEL);
            // covariance correction
            7'd47: return mk(OP_MUL, tmp(10), S_H0,  tmp(13));
            7'd48: return mk(OP_MUL, tmp(11), S_H0,  tmp(14));
            7'd49: return mk(OP_MUL, tmp(10), S_H1,  tmp(15));
            7'd50: return mk(OP_MUL, tmp(11), S_H1,  tmp(16));
            7'd51: return mk(OP_MUL, tmp(13), tmp(5), tmp(17));
            7'd52: return mk(OP_MUL, tmp(15), tmp(6), tmp(18));
            7'd53: return mk(OP_ADD, tmp(17), tmp(18), tmp(17));
            7'd54: return mk(OP_SUB, tmp(5), tmp(17), D_C0);
            7'd55: return mk(OP_MUL, tmp(14), tmp(5), tmp(17));
            7'd56: return mk(OP_MUL, tmp(16), tmp(6), tmp(18));
            7'd57: return mk(OP_ADD, tmp(17), tmp(18), tmp(17));
            7'd58: return mk(OP_SUB, tmp(6), tmp(17), D_C1);
            7'd59: return mk(OP_MUL, tmp(13), tmp(7), tmp(17));
            7'd60: return mk(OP_MUL, tmp(15), tmp(8), tmp(18));
            7'd61: return mk(OP_ADD, tmp(17), tmp(18), tmp(17));
            7'd62: return mk(OP_SUB, tmp(7), tmp(17), D_C2);
            7'd63: return mk(OP_MUL, tmp(14), tmp(7), tmp(17));
            7'd64: return mk(OP_MUL, tmp(16), tmp(8), tmp(18));
            7'd65: return mk(OP_ADD, tmp(17), tmp(18), tmp(17));
            7'd66: return mk(OP_SUB, tmp(8), tmp(17), D_C3);
            7'd67: return mk(OP_END, S_NONE, S_NONE, S_NONE);
            // zero variance: keep the prediction
            7'd68: return mk(OP_MOV, tmp(1), S_NONE, D_POS);
            7'd69: return mk(OP_MOV, tmp(2), S_NONE, D_VEL);
            7'd70: return mk(OP_MOV, tmp(5), S_NONE, D_C0);
            7'd71: return mk(OP_MOV, tmp(6), S_NONE, D_C1);
            7'd72: return mk(OP_MOV, tmp(7), S_NONE, D_C2);
            7'd73: return mk(OP_MOV, tmp(8), S_NONE, D_C3);
            default: return mk(OP_END, S_NONE, S_NONE, S_NONE);
        endcase
    endfunction

endpackage

// ===== rtl/kpv_in_if.sv =====
interface kpv_in_if;
    import kpv_pkg::*;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [TIME_STEP_W-1:0]        time_step;
    logic signed [FIELD_W-1:0]     accel;
    logic signed [FIELD_W-1:0]     obs_position;
    logic signed [FIELD_W-1:0]     init_position;
    logic signed [FIELD_W-1:0]     init_velocity;

    modport source (output valid, operation, time_step, accel, obs_position,
                    init_position, init_velocity, input ready);
    modport sink   (input valid, operation, time_step, accel, obs_position,
                    init_position, init_velocity, output ready);
endinterface

// ===== rtl/kpv_out_if.sv =====
interface kpv_out_if;
    import kpv_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] est_position;
    logic signed [FIELD_W-1:0] est_velocity;
    logic                      update_skipped;

    modport source (output valid, est_position, est_velocity, update_skipped, input ready);
    modport sink   (input valid, est_position, est_velocity, update_skipped, output ready);
endinterface

// ===== rtl/kpv_alu.sv =====
module kpv_alu #(
    parameter int FRAC_BITS  = kpv_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = kpv_pkg::DATA_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              load,
    input  logic [kpv_pkg::OP_W-1:0]          op,
    input  logic signed [DATA_WIDTH-1:0]      a,
    input  logic signed [DATA_WIDTH-1:0]      b,
    output logic signed [DATA_WIDTH-1:0]      result
);
    import kpv_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW + 1;

    logic [OP_W-1:0]       op_reg;
    logic                  neg_reg;
    logic [2*DW-1:0]       prod_reg;
    logic signed [DW:0]    sum_reg;
    logic signed [DW:0]    sum_next;
    logic [DW-1:0]         mag_a;
    logic [DW-1:0]         mag_b;

    logic [PW-1:0]         rounded;
    logic [PW-1:0]         scaled;
    logic [PW-1:0]         lim;
    logic [DW-1:0]         mul_mag;
    logic signed [DW-1:0]  mul_res;
    logic signed [DW-1:0]  sum_res;
    logic signed [DW:0]    hi_x;
    logic signed [DW:0]    lo_x;

    assign mag_a = a[DW-1] ? DW'(-a) : DW'(a);
    assign mag_b = b[DW-1] ? DW'(-b) : DW'(b);

    always_comb
    begin
        case (op)
            OP_ADD:  sum_next = {a[DW-1], a} + {b[DW-1], b};
            OP_SUB:  sum_next = {a[DW-1], a} - {b[DW-1], b};
            OP_SHR:  sum_next = $signed({a[DW-1], a}) >>> 1;
            OP_MOV:  sum_next = {a[DW-1], a};
            default: sum_next = '0;
        endcase
    end

    // first stage: raw product or wide sum
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg   <= op;
            neg_reg  <= a[DW-1] ^ b[DW-1];
            prod_reg <= mag_a * mag_b;
            sum_reg  <= sum_next;
        end
    end

    // second stage: round half away from zero on the magnitude, then saturate
    always_comb
    begin
        rounded = {1'b0, prod_reg} + (PW'(1) << (FRAC_BITS - 1));
        scaled  = rounded >> FRAC_BITS;
        lim     = PW'({(DW-1){1'b1}}) + PW'(neg_reg);
        mul_mag = (scaled > lim) ? lim[DW-1:0] : scaled[DW-1:0];
        mul_res = neg_reg ? -$signed(mul_mag) : $signed(mul_mag);

        hi_x = $signed({2'b00, {(DW-1){1'b1}}});
        lo_x = -hi_x - (DW+1)'(1);
        if (sum_reg > hi_x)
            sum_res = hi_x[DW-1:0];
        else if (sum_reg < lo_x)
            sum_res = lo_x[DW-1:0];
        else
            sum_res = sum_reg[DW-1:0];

        result = (op_reg == OP_MUL) ? mul_res : sum_res;
    end

endmodule

// ===== rtl/kpv_div.sv =====
module kpv_div #(
    parameter int FRAC_BITS  = kpv_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = kpv_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [DATA_WIDTH-1:0]  num,
    input  logic signed [DATA_WIDTH-1:0]  den,
    output logic                          busy,
    output logic                          done,
    output logic signed [DATA_WIDTH-1:0]  quot
);
    localparam int DW = DATA_WIDTH;
    localparam int N  = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(N + 1);

    logic               run_reg;
    logic               fin_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [N-1:0]       dvd_reg;
    logic [N-1:0]       q_reg;
    logic [DW-1:0]      rem_reg;
    logic [DW-1:0]      ud_reg;
    logic               neg_reg;
    logic signed [DW-1:0] quot_reg;

    logic [DW:0]        rem_sh;
    logic               ge;
    logic [DW:0]        rem_sub;
    logic [DW-1:0]      lim;
    logic [DW-1:0]      q_clamp;
    logic [DW-1:0]      mag_num;
    logic [DW-1:0]      mag_den;

    assign mag_num = num[DW-1] ? DW'(-num) : DW'(num);
    assign mag_den = den[DW-1] ? DW'(-den) : DW'(den);

    // one quotient bit a cycle, restoring
    assign rem_sh  = {rem_reg, dvd_reg[N-1]};
    assign ge      = rem_sh >= {1'b0, ud_reg};
    assign rem_sub = rem_sh - {1'b0, ud_reg};

    assign lim     = {1'b0, {(DW-1){1'b1}}} + DW'(neg_reg);
    assign q_clamp = (q_reg > N'(lim)) ? lim : q_reg[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            ud_reg   <= '0;
            neg_reg  <= 1'b0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                dvd_reg <= {mag_num, {FRAC_BITS{1'b0}}};
                q_reg   <= '0;
                rem_reg <= '0;
                ud_reg  <= mag_den;
                neg_reg <= num[DW-1] ^ den[DW-1];
            end
            else if (run_reg)
            begin
                rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                q_reg   <= {q_reg[N-2:0], ge};
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(N - 1))
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
                quot_reg <= neg_reg ? -$signed(q_clamp) : $signed(q_clamp);
            end
        end
    end

    assign busy = run_reg | fin_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/kalman_pos_vel_filter_top.sv =====
// channel   dir   payload
// in_ch     sink  operation, time_step, accel, obs_position, init_position, init_velocity
// out_ch    src   est_position, est_velocity, update_skipped
//
// an init word gives its result without running the program; a filter word runs the program
// step by step, each arithmetic step through the one shared unit, and if the variance is zero
// skips the gains and the correction and keeps the prediction; the divider makes one quotient
// bit a cycle for each of the two gains
// in_ch.ready is high only while no word is in work; a finished word waits in the output
// register, so the next word is taken while out_ch is stalled
// reset clears estimates, loads the covariance diagonal and restores register defaults;
// cov_init_diag takes effect only through reset, which restores it, so writes to it do nothing
`include "kalman_pos_vel_filter_top_assert.svh"

module kalman_pos_vel_filter_top #(
    parameter int FRAC_BITS  = kpv_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = kpv_pkg::DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kpv_in_if.sink                          in_ch,
    kpv_out_if.source                       out_ch,
    input  logic                            cfg_wr_en,
    input  logic [kpv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kpv_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kpv_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int XW = ((DW > FIELD_W) ? DW : FIELD_W) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_DIVW  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    function automatic logic signed [DW-1:0] sat_x(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = (XW'(1) << (DW - 1)) - XW'(1);
        lo = -hi - XW'(1);
        if (x > hi)
            return hi[DW-1:0];
        else if (x < lo)
            return lo[DW-1:0];
        else
            return x[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] from_s32(input logic [FIELD_W-1:0] v);
        return sat_x(XW'($signed(v)));
    endfunction

    function automatic logic [FIELD_W-1:0] out32(input logic signed [DW-1:0] v);
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        x  = XW'(v);
        hi = XW'({1'b0, {(FIELD_W-1){1'b1}}});
        lo = -hi - XW'(1);
        if (x > hi)
            return hi[FIELD_W-1:0];
        else if (x < lo)
            return lo[FIELD_W-1:0];
        else
            return x[FIELD_W-1:0];
    endfunction

    logic [2:0]             state_reg;
    logic [PC_W-1:0]        pc_reg;
    logic                   skipped_reg;

    logic signed [DW-1:0]   q00_reg, q10_reg, q01_reg, q11_reg;
    logic signed [DW-1:0]   r_reg, h0_reg, h1_reg;
    logic signed [DW-1:0]   dt_reg, acc_reg, obs_reg;
    logic signed [DW-1:0]   pos_reg, vel_reg;
    logic signed [DW-1:0]   c0_reg, c1_reg, c2_reg, c3_reg;

    logic signed [DW-1:0]   mem [TMP_DEPTH];
    logic signed [DW-1:0]   rd_a_reg, rd_b_reg;

    logic                   out_valid_reg;
    logic [FIELD_W-1:0]     out_pos_reg, out_vel_reg;
    logic                   out_skip_reg;

    kpv_uop_t               uop;
    logic signed [DW-1:0]   opa, opb;
    logic signed [DW-1:0]   alu_res, div_res, wr_data;
    logic                   alu_load, div_start, div_busy, div_done;
    logic                   wr_en, mem_we, in_fire, out_free;

    assign uop = kpv_rom(pc_reg);

    function automatic logic signed [DW-1:0] fixed_opnd(input logic [OPND_W-1:0] code);
        case (code)
            S_Q00:   return q00_reg;
            S_Q10:   return q10_reg;
            S_Q01:   return q01_reg;
            S_Q11:   return q11_reg;
            S_R:     return r_reg;
            S_H0:    return h0_reg;
            S_H1:    return h1_reg;
            S_DT:    return dt_reg;
            S_ACC:   return acc_reg;
            S_OBS:   return obs_reg;
            S_POS:   return pos_reg;
            S_VEL:   return vel_reg;
            S_C0:    return c0_reg;
            S_C1:    return c1_reg;
            S_C2:    return c2_reg;
            S_C3:    return c3_reg;
            default: return '0;
        endcase
    endfunction

    always_comb
    begin
        opa = uop.a[OPND_W-1] ? rd_a_reg : fixed_opnd(uop.a);
        opb = uop.b[OPND_W-1] ? rd_b_reg : fixed_opnd(uop.b);
    end

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign alu_load  = (state_reg == ST_EXEC) && (uop.op != OP_DIV) && (uop.op != OP_BRZ)
                       && (uop.op != OP_END);
    assign div_start = (state_reg == ST_EXEC) && (uop.op == OP_DIV);
    assign wr_en     = (state_reg == ST_WB) || ((state_reg == ST_DIVW) && div_done);
    assign wr_data   = (state_reg == ST_DIVW) ? div_res : alu_res;
    assign mem_we    = wr_en && uop.d[OPND_W-1];

    kpv_alu #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_alu (
        .clk    (clk),
        .load   (alu_load),
        .op     (uop.op),
        .a      (opa),
        .b      (opb),
        .result (alu_res)
    );

    kpv_div #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (opa),
        .den   (opb),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_res)
    );

    // scratch memory, registered reads at the operand addresses of the current step
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[uop.d[TMP_AW-1:0]] <= wr_data;
        rd_a_reg <= mem[uop.a[TMP_AW-1:0]];
        rd_b_reg <= mem[uop.b[TMP_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q00_reg <= DW'(Q00_RST);
            q10_reg <= '0;
            q01_reg <= '0;
            q11_reg <= DW'(Q11_RST);
            r_reg   <= DW'(R_RST);
            h0_reg  <= DW'(H0_RST);
            h1_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_Q00: q00_reg <= from_s32(cfg_data);
                CFG_Q10: q10_reg <= from_s32(cfg_data);
                CFG_Q01: q01_reg <= from_s32(cfg_data);
                CFG_Q11: q11_reg <= from_s32(cfg_data);
                CFG_R:   r_reg   <= sat_x(XW'({1'b0, cfg_data[FIELD_W-2:0]}));
                CFG_H0:  h0_reg  <= from_s32(cfg_data);
                CFG_H1:  h1_reg  <= from_s32(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            skipped_reg   <= 1'b0;
            dt_reg        <= '0;
            acc_reg       <= '0;
            obs_reg       <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            c0_reg        <= DW'(COV_DIAG_RST);
            c1_reg        <= '0;
            c2_reg        <= '0;
            c3_reg        <= DW'(COV_DIAG_RST);
            out_valid_reg <= 1'b0;
            out_pos_reg   <= '0;
            out_vel_reg   <= '0;
            out_skip_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;

            if (wr_en && !uop.d[OPND_W-1])
            begin
                case (uop.d)
                    D_POS:   pos_reg <= wr_data;
                    D_VEL:   vel_reg <= wr_data;
                    D_C0:    c0_reg  <= wr_data;
                    D_C1:    c1_reg  <= wr_data;
                    D_C2:    c2_reg  <= wr_data;
                    D_C3:    c3_reg  <= wr_data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        skipped_reg <= 1'b0;
                        pc_reg      <= '0;
                        if (in_ch.operation)
                        begin
                            pos_reg   <= from_s32(in_ch.init_position);
                            vel_reg   <= from_s32(in_ch.init_velocity);
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            dt_reg    <= sat_x(XW'(in_ch.time_step));
                            acc_reg   <= from_s32(in_ch.accel);
                            obs_reg   <= from_s32(in_ch.obs_position);
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= (uop.op == OP_END) ? ST_DONE : ST_EXEC;
                end
                ST_EXEC:
                begin
                    case (uop.op)
                        OP_BRZ:
                        begin
                            if (opa == '0)
                            begin
                                pc_reg      <= SKIP_PC;
                                skipped_reg <= 1'b1;
                            end
                            else
                                pc_reg <= pc_reg + PC_W'(1);
                            state_reg <= ST_FETCH;
                        end
                        OP_DIV:  state_reg <= ST_DIVW;
                        default: state_reg <= ST_WB;
                    endcase
                end
                ST_WB:
                begin
                    pc_reg    <= pc_reg + PC_W'(1);
                    state_reg <= ST_FETCH;
                end
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        pc_reg    <= pc_reg + PC_W'(1);
                        state_reg <= ST_FETCH;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pos_reg   <= out32(pos_reg);
                        out_vel_reg   <= out32(vel_reg);
                        out_skip_reg  <= skipped_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ch.ready           = (state_reg == ST_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.est_position   = out_pos_reg;
    assign out_ch.est_velocity   = out_vel_reg;
    assign out_ch.update_skipped = out_skip_reg;

    `KPV_ASSERT_NOW(a_div_only_in_wait, div_busy || div_done, state_reg == ST_DIVW, "divider active outside its wait state")
    `KPV_ASSERT_NOW(a_pc_in_program, state_reg != ST_IDLE, pc_reg < PC_W'(NUM_UOP), "program counter past the program")
    `KPV_ASSERT_NEXT(a_busy_after_accept, in_fire, state_reg != ST_IDLE, "word accepted but sequencer idle")
    `KPV_ASSERT_NEXT(a_done_waits, (state_reg == ST_DONE) && out_valid_reg && !out_ch.ready, state_reg == ST_DONE, "result overwrote a pending word")

endmodule

// ===== tb/sv/kalman_pos_vel_filter_top_test.sv =====
module kalman_pos_vel_filter_top_test;
    import kpv_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd12;
    localparam longint FX_MAX = 64'sd2147483647;
    localparam longint FX_MIN = -64'sd2147483648;
    localparam int NUM_REGS = 8;

    typedef enum logic {OP_FILTER = 1'b0, OP_LOAD = 1'b1} kpv_op_e;

    typedef struct {
        kpv_op_e     op;
        logic [15:0] dt;
        logic [31:0] acc;
        logic [31:0] obs;
        logic [31:0] ld_pos;
        logic [31:0] ld_vel;
    } filt_word_t;

    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic        skipped;
    } est_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kpv_in_if  in_ch();
    kpv_out_if out_ch();

    kalman_pos_vel_filter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    filt_word_t pending_words[$];
    est_word_t  expected_est[$];
    int         error_count = 0;
    bit         no_idle = 0;

    // filter state as tracked on this side
    longint tr_reg[NUM_REGS];
    longint tr_pos, tr_vel;
    longint tr_cov[4];

    function automatic longint fx_sat(input longint x);
        if (x > FX_MAX) return FX_MAX;
        if (x < FX_MIN) return FX_MIN;
        return x;
    endfunction

    function automatic longint unsigned fx_mag(input longint a);
        return (a < 0) ? longint'(-a) : longint'(a);
    endfunction

    function automatic longint fx_signed(input longint unsigned m, input bit neg);
        longint unsigned lim;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (m > lim) m = lim;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fx_add(input longint a, input longint b);
        return fx_sat(a + b);
    endfunction

    function automatic longint fx_sub(input longint a, input longint b);
        return fx_sat(a - b);
    endfunction

    // rounded to nearest on magnitude, halves away from zero
    function automatic longint fx_mul(input longint a, input longint b);
        longint unsigned p;
        p = fx_mag(a) * fx_mag(b) + 64'd32768;
        return fx_signed(p >> 16, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_div(input longint num, input longint den);
        longint unsigned q;
        q = (fx_mag(num) << 16) / fx_mag(den);
        return fx_signed(q, (num < 0) != (den < 0));
    endfunction

    function automatic void tracker_reset();
        tr_reg[CFG_Q00] = 655;
        tr_reg[CFG_Q10] = 0;
        tr_reg[CFG_Q01] = 0;
        tr_reg[CFG_Q11] = 655;
        tr_reg[CFG_R] = 65536;
        tr_reg[CFG_H0] = 65536;
        tr_reg[CFG_H1] = 0;
        tr_reg[CFG_COV_INIT] = 65536;
        tr_pos = 0;
        tr_vel = 0;
        tr_cov[0] = 65536;
        tr_cov[1] = 0;
        tr_cov[2] = 0;
        tr_cov[3] = 65536;
    endfunction

    function automatic est_word_t filter_estimate(input filt_word_t w);
        est_word_t r;
        longint dt, a, hdt2, x0, x1, b00, b01, p00, p10, p01, p11;
        longint h0, h1, s, k0, k1, y, f00, f10, f01, f11;
        r.skipped = 1'b0;
        if (w.op == OP_LOAD) begin
            tr_pos = longint'($signed(w.ld_pos));
            tr_vel = longint'($signed(w.ld_vel));
        end else begin
            dt = longint'(w.dt);
            a = longint'($signed(w.acc));
            hdt2 = fx_mul(dt, dt) >>> 1;
            x0 = fx_add(fx_add(tr_pos, fx_mul(dt, tr_vel)), fx_mul(hdt2, a));
            x1 = fx_add(tr_vel, fx_mul(dt, a));
            b00 = fx_add(tr_cov[0], fx_mul(dt, tr_cov[1]));
            b01 = fx_add(tr_cov[2], fx_mul(dt, tr_cov[3]));
            p00 = fx_add(fx_add(b00, fx_mul(b01, dt)), tr_reg[CFG_Q00]);
            p10 = fx_add(fx_add(tr_cov[1], fx_mul(tr_cov[3], dt)), tr_reg[CFG_Q10]);
            p01 = fx_add(b01, tr_reg[CFG_Q01]);
            p11 = fx_add(tr_cov[3], tr_reg[CFG_Q11]);
            h0 = tr_reg[CFG_H0];
            h1 = tr_reg[CFG_H1];
            s = fx_add(fx_add(fx_mul(fx_add(fx_mul(h0, p00), fx_mul(h1, p10)), h0),
                              fx_mul(fx_add(fx_mul(h0, p01), fx_mul(h1, p11)), h1)),
                       tr_reg[CFG_R]);
            if (s == 0) begin
                r.skipped = 1'b1;
                tr_cov[0] = p00;
                tr_cov[1] = p10;
                tr_cov[2] = p01;
                tr_cov[3] = p11;
            end else begin
                k0 = fx_div(fx_add(fx_mul(p00, h0), fx_mul(p01, h1)), s);
                k1 = fx_div(fx_add(fx_mul(p10, h0), fx_mul(p11, h1)), s);
                y = fx_sub(longint'($signed(w.obs)), fx_add(fx_mul(h0, x0), fx_mul(h1, x1)));
                x0 = fx_add(x0, fx_mul(k0, y));
                x1 = fx_add(x1, fx_mul(k1, y));
                f00 = fx_mul(k0, h0);
                f10 = fx_mul(k1, h0);
                f01 = fx_mul(k0, h1);
                f11 = fx_mul(k1, h1);
                tr_cov[0] = fx_sub(p00, fx_add(fx_mul(f00, p00), fx_mul(f01, p10)));
                tr_cov[1] = fx_sub(p10, fx_add(fx_mul(f10, p00), fx_mul(f11, p10)));
                tr_cov[2] = fx_sub(p01, fx_add(fx_mul(f00, p01), fx_mul(f01, p11)));
                tr_cov[3] = fx_sub(p11, fx_add(fx_mul(f10, p01), fx_mul(f11, p11)));
            end
            tr_pos = x0;
            tr_vel = x1;
        end
        r.pos = tr_pos[31:0];
        r.vel = tr_vel[31:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // driver
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                filt_word_t w;
                w.op = kpv_op_e'(in_ch.operation);
                w.dt = in_ch.time_step;
                w.acc = in_ch.accel;
                w.obs = in_ch.obs_position;
                w.ld_pos = in_ch.init_position;
                w.ld_vel = in_ch.init_velocity;
                expected_est.push_back(filter_estimate(w));
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    filt_word_t w;
                    w = pending_words.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.operation <= w.op;
                    in_ch.time_step <= w.dt;
                    in_ch.accel <= w.acc;
                    in_ch.obs_position <= w.obs;
                    in_ch.init_position <= w.ld_pos;
                    in_ch.init_velocity <= w.ld_vel;
                    send_gap <= pick_gap();
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_est.size() == 0)
                begin
                    report_mismatch("unexpected word", out_ch.est_position, 32'd0);
                end
                else
                begin
                    est_word_t e;
                    e = expected_est.pop_front();
                    if (out_ch.est_position !== e.pos)
                        report_mismatch("est_position", out_ch.est_position, e.pos);
                    if (out_ch.est_velocity !== e.vel)
                        report_mismatch("est_velocity", out_ch.est_velocity, e.vel);
                    if (out_ch.update_skipped !== e.skipped)
                        report_mismatch("update_skipped", 32'(out_ch.update_skipped),
                                        32'(e.skipped));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        // cov_init_diag only matters at reset, which is never repeated
        if (idx == CFG_R)
            tr_reg[idx] = longint'(val[30:0]);
        else if (idx < CFG_COV_INIT)
            tr_reg[idx] = longint'($signed(val));
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_words.size() > 0 || in_ch.valid || expected_est.size() > 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word(input bit wide);
        logic [31:0] v;
        v = $urandom();
        if (!wide) v = {{12{v[31]}}, v[19:0]};
        return v;
    endfunction

    function automatic void push_step(input logic [15:0] dt, input logic [31:0] acc,
                                      input logic [31:0] obs);
        filt_word_t w;
        w.op = OP_FILTER;
        w.dt = dt;
        w.acc = acc;
        w.obs = obs;
        w.ld_pos = $urandom();
        w.ld_vel = $urandom();
        pending_words.push_back(w);
    endfunction

    function automatic void push_load(input logic [31:0] p, input logic [31:0] v);
        filt_word_t w;
        w.op = OP_LOAD;
        w.dt = $urandom();
        w.acc = $urandom();
        w.obs = $urandom();
        w.ld_pos = p;
        w.ld_vel = v;
        pending_words.push_back(w);
    endfunction

    function automatic void push_random(input int n);
        bit wide;
        for (int i = 0; i < n; i++)
        begin
            wide = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                push_load(rand_word(wide), rand_word(wide));
            else
                push_step(wide ? 16'($urandom()) : 16'($urandom_range(0, 4096)),
                          rand_word(wide), rand_word(wide));
        end
    endfunction

    task automatic write_all(input logic [31:0] q00, input logic [31:0] q10,
                             input logic [31:0] q01, input logic [31:0] q11,
                             input logic [31:0] r, input logic [31:0] h0,
                             input logic [31:0] h1);
        write_reg(CFG_Q00, q00);
        write_reg(CFG_Q10, q10);
        write_reg(CFG_Q01, q01);
        write_reg(CFG_Q11, q11);
        write_reg(CFG_R, r);
        write_reg(CFG_H0, h0);
        write_reg(CFG_H1, h1);
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.operation = 1'b0;
        in_ch.time_step = '0;
        in_ch.accel = '0;
        in_ch.obs_position = '0;
        in_ch.init_position = '0;
        in_ch.init_velocity = '0;
        out_ch.ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tracker_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes at reset settings
        push_step(16'd0, 32'd0, 32'd0);
        push_step(16'hffff, 32'h7fffffff, 32'h7fffffff);
        push_step(16'hffff, 32'h80000000, 32'h80000000);
        push_load(32'h7fffffff, 32'h7fffffff);
        push_step(16'hffff, 32'h7fffffff, 32'h7fffffff);
        push_load(32'h80000000, 32'h80000000);
        push_step(16'hffff, 32'h80000000, 32'h80000000);
        push_load(32'd0, 32'd65536);
        push_step(16'h8000, 32'hfffe0000, 32'd100000);
        push_step(16'd1, 32'd1, 32'hffffffff);
        wait_drained();

        // a cov_init_diag write and a stray index, then zero innovation variance
        write_reg(CFG_COV_INIT, 32'h7fffffff);
        write_reg(CFG_UNUSED, 32'hdeadbeef);
        write_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'd0,
                  32'd0, 32'd0);
        push_step(16'h4000, 32'd65536, 32'd12345);
        push_step(16'hffff, 32'h80000000, 32'h7fffffff);
        push_load(32'd1, 32'hffffffff);
        push_step(16'd0, 32'd0, 32'd0);
        push_step(16'h1234, 32'h7fffffff, 32'h80000000);
        wait_drained();

        // extremes everywhere
        write_all(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000);
        push_step(16'hffff, 32'h7fffffff, 32'h80000000);
        push_step(16'h0001, 32'h80000000, 32'h7fffffff);
        push_load(32'd0, 32'd0);
        push_step(16'h8000, 32'd65536, 32'd65536);
        wait_drained();

        for (int phase = 0; phase < 10; phase++)
        begin
            no_idle = (phase % 4 == 3);
            case (phase % 5)
                0: write_all(32'd655, 32'd0, 32'd0, 32'd655, 32'd65536, 32'd65536, 32'd0);
                1: write_all($urandom_range(0, 65536), $urandom_range(0, 2000),
                             $urandom_range(0, 2000), $urandom_range(0, 65536),
                             $urandom_range(1, 1 << 20), $urandom_range(0, 1 << 17),
                             $urandom_range(0, 1 << 15));
                2: write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom());
                3: write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0);
                default: write_all(32'd655, 32'd0, 32'd0, 32'd655, $urandom_range(0, 3),
                                   32'd0, 32'd0);
            endcase
            push_random(105);
            wait_drained();
        end
        no_idle = 0;

        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("kalman_pos_vel_filter_top_test: done, clean");
        else
            $display("kalman_pos_vel_filter_top_test: done, errors");
        $finish;
    end

    initial
    begin
        #200000000;
        $display("timeout at %0t", $time);
        $display("kalman_pos_vel_filter_top_test: done, errors");
        $finish;
    end

endmodule

// ===== kalman_pos_vel_filter_top.f =====
+incdir+rtl
rtl/kpv_pkg.sv
rtl/kpv_in_if.sv
rtl/kpv_out_if.sv
rtl/kpv_alu.sv
rtl/kpv_div.sv
rtl/kalman_pos_vel_filter_top.sv
tb/sv/kalman_pos_vel_filter_top_test.sv
